// ===== hdl/lmbd_pkg.sv =====
package lmbd_pkg;

   localparam int LABEL_W       = 16;
   localparam int ROW_W         = 12;
   localparam int COL_OUT_W     = 10;
   localparam int WIDTH_REG_W   = 11;
   localparam int HEIGHT_REG_W  = 12;
   localparam int MAX_WIDTH_DEF = 1024;

   // nine labels summed, and nine times one label
   localparam int SUM_W     = 20;
   // three labels of one column summed
   localparam int COL_SUM_W = 18;

   localparam int WINDOW_COLS = 3;

   localparam int REQ_DATA_W = 16;
   localparam int RSP_DATA_W = 24;

   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 12;

   localparam logic [CSR_INDEX_W-1:0] CSR_FRAME_WIDTH  = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_FRAME_HEIGHT = 1'b1;

   localparam logic [WIDTH_REG_W-1:0]  FRAME_WIDTH_RST  = 11'd1024;
   localparam logic [HEIGHT_REG_W-1:0] FRAME_HEIGHT_RST = 12'd1024;
   localparam logic [HEIGHT_REG_W-1:0] MIN_HEIGHT       = 12'd3;

   // one window column as a cell holds it: label sum and middle-row label
   typedef struct packed {
      logic [COL_SUM_W-1:0] sum;
      logic [LABEL_W-1:0]   mid;
   } column_type;

endpackage

// ===== hdl/lmbd_ram.sv =====
module lmbd_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hdl/lmbd_window_cell.sv =====
module lmbd_window_cell (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        advance,
   input  lmbd_pkg::column_type        col_in,
   input  logic [lmbd_pkg::SUM_W-1:0]  sum_in,
   output lmbd_pkg::column_type        col_out,
   output logic [lmbd_pkg::SUM_W-1:0]  sum_out
);

   lmbd_pkg::column_type col_ff;
   lmbd_pkg::column_type col_in_mux;

   // take the neighbor's column on every advance, hold otherwise
   always_comb begin
      col_in_mux = advance ? col_in : col_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
      end else begin
         col_ff <= col_in_mux;
      end
   end

   assign col_out = col_ff;
   assign sum_out = sum_in + lmbd_pkg::SUM_W'(col_ff.sum);

endmodule

// ===== hdl/label_map_boundary_detect.sv =====
// A result passes stage 1 and the output register once the item that completes its
//   3x3 window (the pixel below and to the right of the reported one) is accepted.
// Throughput: one item per cycle unless stalled; the line store RAM is read on accept
//   and written one stage later, so each item touches the single memory once per port.
// Reset: synchronous, active high; clears counters, window cells, valid flags and
//   loads both frame registers with 1024. The line store is not cleared.
module label_map_boundary_detect #(
   parameter int MAX_WIDTH = lmbd_pkg::MAX_WIDTH_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   // request stream
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [lmbd_pkg::REQ_DATA_W-1:0]     req_tdata,  // [15:0] label
   // result stream
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [lmbd_pkg::RSP_DATA_W-1:0]     rsp_tdata,  // [11:0] pixel_row,
                                                           // [21:12] pixel_col,
                                                           // [22] is_boundary, [23] zero
   output logic                                rsp_tlast,  // frame_done
   // register write port
   input  logic                                csr_wr_en,
   input  logic [lmbd_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [lmbd_pkg::CSR_DATA_W-1:0]     csr_wr_data
);

   localparam int CW = $clog2(MAX_WIDTH);
   // compare width: holds the width register and the column count plus one
   localparam int EW = (CW + 1 > lmbd_pkg::WIDTH_REG_W) ? CW + 1 : lmbd_pkg::WIDTH_REG_W;
   localparam int LW = lmbd_pkg::LABEL_W;
   localparam int RW = lmbd_pkg::ROW_W;
   localparam int NCELLS = lmbd_pkg::WINDOW_COLS - 1;

   // ---------------------------------------------------------------- registers
   logic [lmbd_pkg::WIDTH_REG_W-1:0]  frame_width_ff, frame_width_in;
   logic [lmbd_pkg::HEIGHT_REG_W-1:0] frame_height_ff, frame_height_in;

   always_comb begin
      frame_width_in  = frame_width_ff;
      frame_height_in = frame_height_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            lmbd_pkg::CSR_FRAME_WIDTH: begin
               frame_width_in = csr_wr_data[lmbd_pkg::WIDTH_REG_W-1:0];
            end
            lmbd_pkg::CSR_FRAME_HEIGHT: begin
               frame_height_in = csr_wr_data;
            end
            default: begin
            end
         endcase
      end
   end

   // Clamp width to 3..MAX_WIDTH and height to at least 3.
   logic [EW-1:0] eff_w;
   logic [RW-1:0] eff_h;

   always_comb begin
      eff_w = EW'(frame_width_ff);
      if (eff_w < EW'(3)) begin
         eff_w = EW'(3);
      end else if (eff_w > EW'(MAX_WIDTH)) begin
         eff_w = EW'(MAX_WIDTH);
      end
      eff_h = (frame_height_ff < lmbd_pkg::MIN_HEIGHT) ? lmbd_pkg::MIN_HEIGHT
                                                       : frame_height_ff;
   end

   // ---------------------------------------------------------------- handshake
   logic s1_valid_ff, s1_valid_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic s1_adv;
   logic accept;

   // Stage 1 drains whenever the output register is free or being emptied.
   assign s1_adv     = s1_valid_ff & (~rsp_valid_ff | rsp_tready);
   assign req_tready = ~s1_valid_ff | s1_adv;
   assign accept     = req_tvalid & req_tready;

   // ---------------------------------------------------------------- position
   logic [CW-1:0] col_ff, col_in;
   logic [RW-1:0] row_ff, row_in;
   logic [EW-1:0] c0;
   logic [EW-1:0] c_plus;
   logic [RW-1:0] r_inc;
   logic [RW-1:0] r0;
   logic          col_wrap;

   always_comb begin
      // late wrap: a register write may have moved the last position below us
      col_wrap = (EW'(col_ff) >= eff_w);
      c0       = col_wrap ? '0 : EW'(col_ff);
      r_inc    = col_wrap ? row_ff + RW'(1) : row_ff;
      r0       = (r_inc >= eff_h) ? '0 : r_inc;
      c_plus   = c0 + EW'(1);

      col_in = col_ff;
      row_in = row_ff;
      if (accept) begin
         if (c_plus >= eff_w) begin
            col_in = '0;
            row_in = (r0 + RW'(1) >= eff_h) ? '0 : r0 + RW'(1);
         end else begin
            col_in = c_plus[CW-1:0];
            row_in = r0;
         end
      end
   end

   // ---------------------------------------------------------------- line store
   // One RAM word per column: upper row in the high half, middle row in the low.
   logic [2*LW-1:0] ls_rd_data;
   logic [2*LW-1:0] ls_wr_data;
   logic [CW-1:0]   s1_addr_ff, s1_addr_in;
   logic [LW-1:0]   s1_lab_ff, s1_lab_in;
   logic [LW-1:0]   up_lab;
   logic [LW-1:0]   mid_lab;

   assign up_lab     = ls_rd_data[2*LW-1:LW];
   assign mid_lab    = ls_rd_data[LW-1:0];
   // shift the column down one row: middle becomes upper, new label becomes middle
   assign ls_wr_data = {mid_lab, s1_lab_ff};

   lmbd_ram #(
      .WIDTH (2 * LW),
      .DEPTH (MAX_WIDTH)
   ) u_line_store (
      .clock   (clock),
      .wr_en   (s1_adv),
      .wr_addr (s1_addr_ff),
      .wr_data (ls_wr_data),
      .rd_en   (accept),
      .rd_addr (c0[CW-1:0]),
      .rd_data (ls_rd_data)
   );

   // ---------------------------------------------------------------- stage 1
   logic                           s1_emit_ff, s1_emit_in;
   logic                           s1_last_ff, s1_last_in;
   logic [RW-1:0]                  s1_row_ff, s1_row_in;
   logic [lmbd_pkg::COL_OUT_W-1:0] s1_col_ff, s1_col_in;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      s1_emit_in  = s1_emit_ff;
      s1_last_in  = s1_last_ff;
      s1_row_in   = s1_row_ff;
      s1_col_in   = s1_col_ff;
      s1_lab_in   = s1_lab_ff;
      s1_addr_in  = s1_addr_ff;
      if (accept) begin
         s1_valid_in = 1'b1;
         // report the interior pixel up and to the left once two rows and columns are in
         s1_emit_in  = (r0 >= RW'(2)) & (c0 >= EW'(2));
         s1_last_in  = (r0 == eff_h - RW'(1)) & (c0 == eff_w - EW'(1));
         s1_row_in   = r0 - RW'(1);
         s1_col_in   = lmbd_pkg::COL_OUT_W'(c0 - EW'(1));
         s1_lab_in   = req_tdata[LW-1:0];
         s1_addr_in  = c0[CW-1:0];
      end else if (s1_adv) begin
         s1_valid_in = 1'b0;
      end
   end

   // ---------------------------------------------------------------- window cells
   lmbd_pkg::column_type              s1_column;
   lmbd_pkg::column_type              cell_col [NCELLS];
   logic [lmbd_pkg::SUM_W-1:0]        cell_sum [NCELLS];
   logic [lmbd_pkg::SUM_W-1:0]        win_sum;
   logic [lmbd_pkg::SUM_W-1:0]        centre;
   logic [lmbd_pkg::SUM_W-1:0]        centre_x9;
   logic                              is_boundary;

   always_comb begin
      s1_column.sum = lmbd_pkg::COL_SUM_W'(up_lab) + lmbd_pkg::COL_SUM_W'(mid_lab)
                    + lmbd_pkg::COL_SUM_W'(s1_lab_ff);
      s1_column.mid = mid_lab;
   end

   // Cell 0 holds column c-1, cell 1 column c-2; each adds its sum to the chain.
   for (genvar k = 0; k < NCELLS; k++) begin : g_cell
      if (k == 0) begin : g_head
         lmbd_window_cell u_cell (
            .clock   (clock),
            .reset   (reset),
            .advance (s1_adv),
            .col_in  (s1_column),
            .sum_in  (lmbd_pkg::SUM_W'(s1_column.sum)),
            .col_out (cell_col[k]),
            .sum_out (cell_sum[k])
         );
      end else begin : g_body
         lmbd_window_cell u_cell (
            .clock   (clock),
            .reset   (reset),
            .advance (s1_adv),
            .col_in  (cell_col[k-1]),
            .sum_in  (cell_sum[k-1]),
            .col_out (cell_col[k]),
            .sum_out (cell_sum[k])
         );
      end
   end

   assign win_sum     = cell_sum[NCELLS-1];
   assign centre      = lmbd_pkg::SUM_W'(cell_col[0].mid);
   assign centre_x9   = (centre << 3) + centre;
   assign is_boundary = (win_sum != centre_x9);

   // ---------------------------------------------------------------- output
   logic [RW-1:0]                  rsp_row_ff, rsp_row_in;
   logic [lmbd_pkg::COL_OUT_W-1:0] rsp_col_ff, rsp_col_in;
   logic                           rsp_bnd_ff, rsp_bnd_in;
   logic                           rsp_last_ff, rsp_last_in;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_row_in   = rsp_row_ff;
      rsp_col_in   = rsp_col_ff;
      rsp_bnd_in   = rsp_bnd_ff;
      rsp_last_in  = rsp_last_ff;
      if (s1_adv && s1_emit_ff) begin
         rsp_valid_in = 1'b1;
         rsp_row_in   = s1_row_ff;
         rsp_col_in   = s1_col_ff;
         rsp_bnd_in   = is_boundary;
         rsp_last_in  = s1_last_ff;
      end else if (rsp_tready) begin
         // drop the item once taken
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff  <= lmbd_pkg::FRAME_WIDTH_RST;
         frame_height_ff <= lmbd_pkg::FRAME_HEIGHT_RST;
         col_ff          <= '0;
         row_ff          <= '0;
         s1_valid_ff     <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         frame_width_ff  <= frame_width_in;
         frame_height_ff <= frame_height_in;
         col_ff          <= col_in;
         row_ff          <= row_in;
         s1_valid_ff     <= s1_valid_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_emit_ff  <= s1_emit_in;
      s1_last_ff  <= s1_last_in;
      s1_row_ff   <= s1_row_in;
      s1_col_ff   <= s1_col_in;
      s1_lab_ff   <= s1_lab_in;
      s1_addr_ff  <= s1_addr_in;
      rsp_row_ff  <= rsp_row_in;
      rsp_col_ff  <= rsp_col_in;
      rsp_bnd_ff  <= rsp_bnd_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, rsp_bnd_ff, rsp_col_ff, rsp_row_ff};
   assign rsp_tlast  = rsp_last_ff;

endmodule

// ===== hdl/lmbd_checker.sv =====
module lmbd_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_tready,
   input logic                             rsp_tvalid,
   input logic                             rsp_tready,
   input logic [lmbd_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   input logic                             rsp_tlast
);

   // a stalled result holds still
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("result changed while stalled");

   // reset empties the output register
   a_rsp_reset: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid right after reset");

   // with no result pending the pipeline always has room for an item
   a_ready_free: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("input stalled with empty output");

   // no result is reported for the first row
   a_row_interior: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[11:0] != 12'd0)
      else $error("result reported for first row");

endmodule

bind label_map_boundary_detect lmbd_checker u_lmbd_checker (
   .clock       (clock),
   .reset       (reset),
   .req_tready  (req_tready),
   .rsp_tvalid  (rsp_tvalid),
   .rsp_tready  (rsp_tready),
   .rsp_tdata   (rsp_tdata),
   .rsp_tlast   (rsp_tlast)
);

// ===== tb/sv/tb.sv =====
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int MAX_LINE       = lmbd_pkg::MAX_WIDTH_DEF;
   localparam int WINDOW_CELLS   = 9;
   localparam int RANDOM_LABELS  = 320;
   localparam int WIDE_LABELS    = 200;
   localparam int SETTLE_CYCLES  = 4;
   localparam int STALL_LIMIT    = 5000;
   localparam int IDLE_PERCENT   = 11;

   // how the labels of a frame are painted
   typedef enum int {
      PAINT_NOISE,
      PAINT_FEW,
      PAINT_REGIONS
   } paint_mode_type;

   // Shadow of the block: frame registers, line stores, window and raster
   // position, plus the queue of boundary verdicts still owed by the block.
   class boundary_scoreboard;
      typedef struct packed {
         logic [lmbd_pkg::ROW_W-1:0]     row;
         logic [lmbd_pkg::COL_OUT_W-1:0] col;
         logic                           is_boundary;
         logic                           frame_done;
      } verdict_type;

      logic [lmbd_pkg::WIDTH_REG_W-1:0]  width_reg;
      logic [lmbd_pkg::HEIGHT_REG_W-1:0] height_reg;
      logic [lmbd_pkg::LABEL_W-1:0]      upper_row [MAX_LINE];
      logic [lmbd_pkg::LABEL_W-1:0]      middle_row [MAX_LINE];
      logic [lmbd_pkg::LABEL_W-1:0]      window [6];
      int unsigned                       col_pos;
      int unsigned                       row_pos;
      verdict_type                       verdicts_due [$];
      int unsigned                       errors;
      int unsigned                       verdicts_checked;
      int unsigned                       labels_seen;

      function new();
         width_reg  = lmbd_pkg::FRAME_WIDTH_RST;
         height_reg = lmbd_pkg::FRAME_HEIGHT_RST;
         foreach (upper_row[i]) upper_row[i] = '0;
         foreach (middle_row[i]) middle_row[i] = '0;
         foreach (window[i]) window[i] = '0;
         col_pos = 0;
         row_pos = 0;
         errors = 0;
         verdicts_checked = 0;
         labels_seen = 0;
      endfunction

      // clamp the width register to 3..MAX_LINE
      function int unsigned line_width();
         int unsigned w;
         w = 32'(width_reg);
         if (w < 3) w = 3;
         if (w > MAX_LINE) w = MAX_LINE;
         return w;
      endfunction

      function int unsigned frame_rows();
         int unsigned h;
         h = 32'(height_reg);
         if (h < 32'(lmbd_pkg::MIN_HEIGHT)) h = 32'(lmbd_pkg::MIN_HEIGHT);
         return h;
      endfunction

      function void write_register(logic [lmbd_pkg::CSR_INDEX_W-1:0] index,
                                   logic [lmbd_pkg::CSR_DATA_W-1:0] value);
         if (index == lmbd_pkg::CSR_FRAME_WIDTH)
            width_reg = value[lmbd_pkg::WIDTH_REG_W-1:0];
         else if (index == lmbd_pkg::CSR_FRAME_HEIGHT)
            height_reg = value[lmbd_pkg::HEIGHT_REG_W-1:0];
      endfunction

      // true when the next label lands on row 0, column 0
      function bit at_frame_start();
         int unsigned c;
         int unsigned r;
         c = col_pos;
         r = row_pos;
         if (c >= line_width()) begin
            c = 0;
            r++;
         end
         if (r >= frame_rows()) r = 0;
         return (c == 0) && (r == 0);
      endfunction

      function void note_label(logic [lmbd_pkg::LABEL_W-1:0] lab);
         int unsigned w;
         int unsigned h;
         int unsigned c;
         int unsigned r;
         int unsigned idx;
         int unsigned sum;
         logic [lmbd_pkg::LABEL_W-1:0] up;
         logic [lmbd_pkg::LABEL_W-1:0] mid;
         verdict_type v;
         w = line_width();
         h = frame_rows();
         labels_seen++;
         // a register change can leave the position past its new end: wrap now
         if (col_pos >= w) begin
            col_pos = 0;
            row_pos++;
         end
         if (row_pos >= h) row_pos = 0;
         c = col_pos;
         r = row_pos;
         idx = c % MAX_LINE;
         up = upper_row[idx];
         mid = middle_row[idx];
         if (r >= 2 && c >= 2) begin
            sum = 32'(up) + 32'(mid) + 32'(lab);
            foreach (window[k]) sum += 32'(window[k]);
            v.row         = lmbd_pkg::ROW_W'(r - 1);
            v.col         = lmbd_pkg::COL_OUT_W'(c - 1);
            v.is_boundary = (sum != WINDOW_CELLS * 32'(window[1]));
            v.frame_done  = (r == h - 1) && (c == w - 1);
            verdicts_due.push_back(v);
         end
         // shift the window one column and refresh the line stores
         window[3] = window[0];
         window[4] = window[1];
         window[5] = window[2];
         window[0] = up;
         window[1] = mid;
         window[2] = lab;
         upper_row[idx] = mid;
         middle_row[idx] = lab;
         col_pos = c + 1;
         if (col_pos >= w) begin
            col_pos = 0;
            row_pos = r + 1;
            if (row_pos >= h) row_pos = 0;
         end
      endfunction

      function void compare_field(string name, logic [31:0] want, logic [31:0] got);
         if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            errors++;
         end
      endfunction

      function void check_result(logic [lmbd_pkg::RSP_DATA_W-1:0] data, logic last);
         verdict_type v;
         if (verdicts_due.size() == 0) begin
            $error("result with no verdict pending: row %0d col %0d",
                   data[lmbd_pkg::ROW_W-1:0], data[lmbd_pkg::ROW_W +: lmbd_pkg::COL_OUT_W]);
            errors++;
            return;
         end
         v = verdicts_due.pop_front();
         verdicts_checked++;
         compare_field("pixel_row", 32'(v.row), 32'(data[lmbd_pkg::ROW_W-1:0]));
         compare_field("pixel_col", 32'(v.col),
                       32'(data[lmbd_pkg::ROW_W +: lmbd_pkg::COL_OUT_W]));
         compare_field("is_boundary", 32'(v.is_boundary),
                       32'(data[lmbd_pkg::ROW_W + lmbd_pkg::COL_OUT_W]));
         compare_field("pad", 32'd0,
                       32'(data[lmbd_pkg::RSP_DATA_W-1:
                                lmbd_pkg::ROW_W + lmbd_pkg::COL_OUT_W + 1]));
         compare_field("frame_done", 32'(v.frame_done), 32'(last));
      endfunction

      function int unsigned pending();
         return verdicts_due.size();
      endfunction
   endclass

   logic                                  clock = 1'b0;
   logic                                  reset;
   logic                                  req_tvalid;
   logic                                  req_tready;
   logic [lmbd_pkg::REQ_DATA_W-1:0]       req_tdata;   // [15:0] label
   logic                                  rsp_tvalid;
   logic                                  rsp_tready;
   logic [lmbd_pkg::RSP_DATA_W-1:0]       rsp_tdata;   // [11:0] pixel_row, [21:12] pixel_col,
                                                       // [22] is_boundary, [23] zero
   logic                                  rsp_tlast;   // frame_done
   logic                                  csr_wr_en;
   logic [lmbd_pkg::CSR_INDEX_W-1:0]      csr_index;
   logic [lmbd_pkg::CSR_DATA_W-1:0]       csr_wr_data;

   boundary_scoreboard                    sb = new();
   bit                                    no_idle = 1'b0;
   int unsigned                           size_settings = 0;
   logic [lmbd_pkg::LABEL_W-1:0]          region_label = '0;

   // values seen at the falling edge decide what the next rising edge accepts
   bit                                    req_take;
   bit                                    rsp_take;
   logic [lmbd_pkg::RSP_DATA_W-1:0]       rsp_word;
   logic                                  rsp_last;
   int unsigned                           stall_cycles = 0;

   label_map_boundary_detect i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Sample both handshakes mid-cycle, where inputs and outputs are settled.
   always @(negedge clock) begin
      req_take = !reset && req_tvalid && req_tready;
      rsp_take = !reset && rsp_tvalid && rsp_tready;
      rsp_word = rsp_tdata;
      rsp_last = rsp_tlast;
   end

   // Check each accepted result, then pick the ready for the next cycle.
   always @(posedge clock) begin
      if (rsp_take) sb.check_result(rsp_word, rsp_last);
      rsp_tready <= no_idle || ($urandom_range(0, 99) >= IDLE_PERCENT);
   end

   // Watchdog: end the run when neither side moves an item for too long.
   always @(posedge clock) begin
      if (req_take || rsp_take) begin
         stall_cycles = 0;
      end else begin
         stall_cycles++;
         if (stall_cycles >= STALL_LIMIT) begin
            $display("timeout after %0d cycles without an item moving", stall_cycles);
            $display("FAIL");
            $finish;
         end
      end
   end

   function automatic logic [lmbd_pkg::LABEL_W-1:0] next_label(paint_mode_type mode);
      case (mode)
         PAINT_FEW: begin
            return lmbd_pkg::LABEL_W'($urandom_range(0, 3));
         end
         PAINT_REGIONS: begin
            // hold a label for a while to form flat segments with edges
            if ($urandom_range(0, 7) == 0) begin
               region_label = lmbd_pkg::LABEL_W'($urandom_range(0, 65535));
            end
            return region_label;
         end
         default: begin
            return lmbd_pkg::LABEL_W'($urandom_range(0, 65535));
         end
      endcase
   endfunction

   // Present one label, idling first at random; return after it is accepted.
   task automatic send_label(input logic [lmbd_pkg::LABEL_W-1:0] lab);
      bit ready_seen;
      while (!no_idle && $urandom_range(0, 99) < IDLE_PERCENT) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= lab;
      do begin
         @(negedge clock);
         ready_seen = req_tready;
         @(posedge clock);
      end while (!ready_seen);
      sb.note_label(lab);
   endtask

   // Stream labels until the raster position is back at the frame start.
   task automatic paint_frame(input paint_mode_type mode);
      do send_label(next_label(mode));
      while (!sb.at_frame_start());
   endtask

   task automatic paint_labels(input int count, input paint_mode_type mode);
      repeat (count) send_label(next_label(mode));
   endtask

   // Drop valid, wait for every owed verdict, then let border items settle.
   task automatic drain();
      req_tvalid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Write both frame registers while the block is idle.
   task automatic set_frame_size(input logic [lmbd_pkg::CSR_DATA_W-1:0] width_val,
                                 input logic [lmbd_pkg::CSR_DATA_W-1:0] height_val);
      drain();
      csr_wr_en   <= 1'b1;
      csr_index   <= lmbd_pkg::CSR_FRAME_WIDTH;
      csr_wr_data <= width_val;
      @(posedge clock);
      sb.write_register(lmbd_pkg::CSR_FRAME_WIDTH, width_val);
      csr_index   <= lmbd_pkg::CSR_FRAME_HEIGHT;
      csr_wr_data <= height_val;
      @(posedge clock);
      sb.write_register(lmbd_pkg::CSR_FRAME_HEIGHT, height_val);
      csr_wr_en   <= 1'b0;
      size_settings++;
   endtask

   initial begin
      // neighbors differ from the centre yet sum to nine times it
      logic [lmbd_pkg::LABEL_W-1:0]    balanced [9];
      int unsigned                     random_start;
      logic [lmbd_pkg::CSR_DATA_W-1:0] w;
      logic [lmbd_pkg::CSR_DATA_W-1:0] h;
      balanced = '{16'd0, 16'd2, 16'd0, 16'd2, 16'd1, 16'd0, 16'd2, 16'd0, 16'd2};

      reset       = 1'b1;
      req_tvalid  = 1'b0;
      req_tdata   = '0;
      rsp_tready  = 1'b0;
      csr_wr_en   = 1'b0;
      csr_index   = lmbd_pkg::CSR_FRAME_WIDTH;
      csr_wr_data = '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: smallest frame with a balanced window (no boundary flagged).
      set_frame_size(12'd3, 12'd3);
      foreach (balanced[i]) send_label(balanced[i]);

      // Directed: full-scale labels, last column zero; first window flat,
      // second one straddles the edge.
      set_frame_size(12'd4, 12'd3);
      for (int i = 0; i < 12; i++) send_label((i % 4 == 3) ? 16'h0000 : 16'hFFFF);

      // Shrink the width mid-frame so the column counter is past its new end.
      set_frame_size(12'd8, 12'd6);
      paint_labels(21, PAINT_NOISE);
      set_frame_size(12'd4, 12'd6);
      paint_frame(PAINT_FEW);

      // Shrink the height mid-frame so the row counter is past its new end.
      set_frame_size(12'd5, 12'd8);
      paint_labels(27, PAINT_REGIONS);
      set_frame_size(12'd5, 12'd4);
      paint_frame(PAINT_NOISE);

      // Undersized registers clamp to three.
      set_frame_size(12'd0, 12'd0);
      repeat (2) paint_frame(PAINT_NOISE);
      set_frame_size(12'd1, 12'd1);
      paint_frame(PAINT_FEW);
      set_frame_size(12'd2, 12'd2);
      paint_frame(PAINT_REGIONS);

      // Random frames, mostly small.
      random_start = sb.labels_seen;
      while (sb.labels_seen - random_start < RANDOM_LABELS) begin
         w = ($urandom_range(0, 7) == 0) ? lmbd_pkg::CSR_DATA_W'($urandom_range(13, 40))
                                         : lmbd_pkg::CSR_DATA_W'($urandom_range(3, 12));
         h = lmbd_pkg::CSR_DATA_W'($urandom_range(3, 8));
         set_frame_size(w, h);
         repeat ($urandom_range(1, 2)) paint_frame(paint_mode_type'($urandom_range(0, 2)));
      end

      // Part of the widest line with no idling on either side, then narrow
      // the frame so the column counter wraps and the frame completes.
      set_frame_size(12'd1024, 12'd3);
      no_idle = 1'b1;
      paint_labels(WIDE_LABELS, PAINT_REGIONS);
      set_frame_size(12'd5, 12'd3);
      paint_frame(PAINT_NOISE);
      drain();
      no_idle = 1'b0;

      // All-ones width register: masked to 2047, clamped to the widest line.
      set_frame_size(12'hFFF, 12'd3);
      paint_labels(40, PAINT_NOISE);
      set_frame_size(12'd3, 12'd3);
      paint_frame(PAINT_NOISE);

      // Tallest height register on the narrowest line, cut short mid-frame.
      set_frame_size(12'd3, 12'd4095);
      paint_labels(36, PAINT_FEW);
      set_frame_size(12'd3, 12'd13);
      paint_frame(PAINT_FEW);

      drain();
      repeat (8) @(posedge clock);

      $display("Streamed %0d labels and checked %0d verdicts over %0d frame sizes,",
               sb.labels_seen, sb.verdicts_checked, size_settings);
      $display("with clamped registers, mid-frame resizing and the widest and tallest sizes.");
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
